/* rtl/core/ipsv_pkg.sv */
package ipsv_pkg;

  localparam int unsigned CordicSteps = 20;
  localparam logic [31:0] CordicGain  = 32'd652032875;
  localparam logic [15:0] Sqrt3Q15    = 16'd56756;
  localparam logic [17:0] RatioMax    = 18'd131072;
  localparam logic [17:0] SatLimit    = 18'd131073;
  localparam logic [31:0] Recip3      = 32'hAAAA_AAAB;

  localparam logic REG_BUS_VOLTAGE = 1'b0;
  localparam logic REG_PWM_PERIOD  = 1'b1;

  typedef enum logic [2:0] {
    SEC_1,
    SEC_2,
    SEC_3,
    SEC_4,
    SEC_5,
    SEC_6
  } sector_e;

  typedef struct packed {
    logic signed [15:0] volt_q;
    logic signed [15:0] volt_d;
    logic [15:0]        rotor_angle;
  } cmd_t;

  typedef struct packed {
    logic [15:0] duty_u;
    logic [15:0] duty_v;
    logic [15:0] duty_w;
    logic [2:0]  sector_num;
  } res_t;

  typedef struct packed {
    logic        reg_idx;
    logic [15:0] wdata;
  } cfg_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [17:0] ratio;
  } mag_t;

  typedef struct packed {
    logic [17:0] ratio;
    sector_e     sec;
    logic [30:0] a_s;
    logic [30:0] a_e;
  } ang_t;

  typedef struct packed {
    logic [17:0]      ratio;
    sector_e          sec;
    logic [1:0][15:0] s;
  } snc_t;

  function automatic logic [31:0] atan_tab(input int unsigned i);
    logic [31:0] r;
    case (i)
      0:       r = 32'd536870912;
      1:       r = 32'd316933406;
      2:       r = 32'd167458907;
      3:       r = 32'd85004756;
      4:       r = 32'd42667331;
      5:       r = 32'd21354465;
      6:       r = 32'd10679838;
      7:       r = 32'd5340245;
      8:       r = 32'd2670163;
      9:       r = 32'd1335087;
      10:      r = 32'd667544;
      11:      r = 32'd333772;
      12:      r = 32'd166886;
      13:      r = 32'd83443;
      14:      r = 32'd41722;
      15:      r = 32'd20861;
      16:      r = 32'd10430;
      17:      r = 32'd5215;
      18:      r = 32'd2608;
      19:      r = 32'd1304;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

/* rtl/core/ipsv_chan_if.sv */
interface ipsv_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/inverse_park_svpwm_duty.sv */
// Inverse Park transform and centre-aligned space vector PWM duty generator.
// cmd_i takes one word per cycle unless stalled: volt_q, volt_d (signed Q7.8
// volts) and rotor_angle (one turn is 2^ANGLE_BITS). duty_o returns one word
// per command: the U, V and W compare values, saturated to 0..the PWM period,
// and sector 1..6. cfg_i writes bus_voltage (index 0) and the PWM period
// (index 1); it is always ready and is meant to be written while no command is
// in flight. The pipeline has 103 register stages. Throughput: one command per
// cycle unless duty_o stalls. The length is set by the 31-step square root,
// the 18-step bus divide and the two 20-step CORDIC chains (atan2, then both
// sines in parallel).
// Each stage holds a valid bit and only waits when the stage after it is
// full, so a stall on duty_o fills empty stages before cmd_i drops ready.
// Reset empties the pipeline and loads bus_voltage 6144 and a PWM period of 4250.
module inverse_park_svpwm_duty #(
  parameter int unsigned ANGLE_BITS = 16
) (
  input logic         clk_i,
  input logic         rst_ni,
  ipsv_chan_if.sink   cmd_i,
  ipsv_chan_if.source duty_o,
  ipsv_chan_if.sink   cfg_i
);
  import ipsv_pkg::*;

  logic [14:0] bus_q;
  logic [15:0] per_q;

  logic vld_n, rdy_n, vld_a, rdy_a, vld_s, rdy_s;
  mag_t dat_n;
  ang_t dat_a;
  snc_t dat_s;
  cmd_t cmd_w;
  res_t res_w;
  cfg_t cfg_w;

  assign cmd_w        = cmd_i.data;
  assign cfg_w        = cfg_i.data;
  assign cfg_i.ready  = 1'b1;
  assign duty_o.data  = res_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bus_q <= 15'd6144;
      per_q <= 16'd4250;
    end else if (cfg_i.valid) begin
      case (cfg_w.reg_idx)
        REG_BUS_VOLTAGE: bus_q <= cfg_w.wdata[14:0];
        REG_PWM_PERIOD:  per_q <= cfg_w.wdata;
        default: begin
        end
      endcase
    end
  end

  ipsv_norm u_norm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .bus_i  (bus_q),
    .vld_i  (cmd_i.valid),
    .rdy_o  (cmd_i.ready),
    .dat_i  (cmd_w),
    .vld_o  (vld_n),
    .rdy_i  (rdy_n),
    .dat_o  (dat_n)
  );

  ipsv_angle #(
    .AngleBits (ANGLE_BITS)
  ) u_angle (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (vld_n),
    .rdy_o  (rdy_n),
    .dat_i  (dat_n),
    .vld_o  (vld_a),
    .rdy_i  (rdy_a),
    .dat_o  (dat_a)
  );

  ipsv_sin u_sin (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (vld_a),
    .rdy_o  (rdy_a),
    .dat_i  (dat_a),
    .vld_o  (vld_s),
    .rdy_i  (rdy_s),
    .dat_o  (dat_s)
  );

  ipsv_duty u_duty (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .per_i  (per_q),
    .vld_i  (vld_s),
    .rdy_o  (rdy_s),
    .dat_i  (dat_s),
    .vld_o  (duty_o.valid),
    .rdy_i  (duty_o.ready),
    .dat_o  (res_w)
  );

  a_sector_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    duty_o.valid |-> res_w.sector_num >= 3'd1 && res_w.sector_num <= 3'd6)
    else $error("sector out of range");

  a_duty_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    duty_o.valid |-> res_w.duty_u <= per_q && res_w.duty_v <= per_q &&
                     res_w.duty_w <= per_q)
    else $error("compare value above period");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.ready |-> duty_o.valid && !duty_o.ready)
    else $error("input held off while pipeline can advance");
endmodule

/* rtl/core/ipsv_norm.sv */
module ipsv_norm (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [14:0]    bus_i,
  input  logic           vld_i,
  output logic           rdy_o,
  input  ipsv_pkg::cmd_t dat_i,
  output logic           vld_o,
  input  logic           rdy_i,
  output ipsv_pkg::mag_t dat_o
);
  import ipsv_pkg::*;

  localparam int unsigned NumSt = 52;

  typedef struct packed {
    cmd_t        cmd;
    logic [30:0] sq_a;
    logic [30:0] sq_b;
    logic [62:0] rem;
    logic [30:0] root;
    logic        sat;
    logic [17:0] quo;
  } st_t;

  st_t              st_q [NumSt];
  st_t              st_d [NumSt];
  st_t              src  [NumSt];
  logic [NumSt-1:0] vld_q, rdy, vld_up, rdy_dn;
  logic [14:0]      beff;

  assign beff   = (bus_i == '0) ? 15'd1 : bus_i;
  assign vld_up = {vld_q[NumSt-2:0], vld_i};
  assign rdy_dn = {rdy_i, rdy[NumSt-1:1]};
  assign rdy    = ~vld_q | rdy_dn;

  for (genvar k = 0; k < NumSt; k++) begin : g_st
    if (k == 0) begin : g_src0
      always_comb begin
        src[k]     = '0;
        src[k].cmd = dat_i;
      end
    end else begin : g_srcn
      always_comb begin
        src[k] = st_q[k-1];
      end
    end

    if (k == 0) begin : g_sq
      always_comb begin
        logic signed [31:0] pa, pb;
        pa = $signed(src[k].cmd.volt_q) * $signed(src[k].cmd.volt_q);
        pb = $signed(src[k].cmd.volt_d) * $signed(src[k].cmd.volt_d);
        st_d[k]      = src[k];
        st_d[k].sq_a = pa[30:0];
        st_d[k].sq_b = pb[30:0];
      end
    end else if (k == 1) begin : g_sum
      always_comb begin
        st_d[k]      = src[k];
        st_d[k].rem  = {1'b0, 32'(src[k].sq_a) + 32'(src[k].sq_b), 30'b0};
        st_d[k].root = '0;
      end
    end else if (k <= 32) begin : g_sqrt
      localparam int B = 32 - k;
      always_comb begin
        logic [62:0] trial;
        trial   = (63'(src[k].root) << (B + 1)) | (63'(1) << (2 * B));
        st_d[k] = src[k];
        if (src[k].rem >= trial) begin
          st_d[k].rem     = src[k].rem - trial;
          st_d[k].root[B] = 1'b1;
        end
      end
    end else if (k == 33) begin : g_sat
      always_comb begin
        logic [32:0] lim;
        lim         = 33'(beff) * 33'(SatLimit);
        st_d[k]     = src[k];
        st_d[k].sat = 33'(src[k].root) >= lim;
        st_d[k].rem = 63'(src[k].root);
        st_d[k].quo = '0;
      end
    end else begin : g_div
      localparam int I = 51 - k;
      always_comb begin
        logic [32:0] dv;
        dv      = 33'(beff) << I;
        st_d[k] = src[k];
        if (src[k].rem[32:0] >= dv) begin
          st_d[k].rem    = 63'(src[k].rem[32:0] - dv);
          st_d[k].quo[I] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NumSt; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vld_up[k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NumSt; k++) begin
      if (rdy[k] && vld_up[k]) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  assign rdy_o       = rdy[0];
  assign vld_o       = vld_q[NumSt-1];
  assign dat_o.cmd   = st_q[NumSt-1].cmd;
  assign dat_o.ratio = st_q[NumSt-1].sat ? RatioMax : st_q[NumSt-1].quo;
endmodule

/* rtl/core/ipsv_angle.sv */
module ipsv_angle #(
  parameter int unsigned AngleBits = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           vld_i,
  output logic           rdy_o,
  input  ipsv_pkg::mag_t dat_i,
  output logic           vld_o,
  input  logic           rdy_i,
  output ipsv_pkg::ang_t dat_o
);
  import ipsv_pkg::*;

  localparam int unsigned NumSt = 24;
  localparam int unsigned SixW  = AngleBits + 3;

  typedef struct packed {
    logic [17:0]          ratio;
    logic [15:0]          rot;
    logic signed [33:0]   xs;
    logic signed [33:0]   ys;
    logic [31:0]          z;
    logic [AngleBits-1:0] theta;
    sector_e              sec;
    logic [31:0]          fe;
    logic [32:0]          fs;
    logic [30:0]          a_s;
    logic [30:0]          a_e;
  } st_t;

  st_t              st_q [NumSt];
  st_t              st_d [NumSt];
  st_t              src  [NumSt];
  logic [NumSt-1:0] vld_q, rdy, vld_up, rdy_dn;

  assign vld_up = {vld_q[NumSt-2:0], vld_i};
  assign rdy_dn = {rdy_i, rdy[NumSt-1:1]};
  assign rdy    = ~vld_q | rdy_dn;

  for (genvar k = 0; k < NumSt; k++) begin : g_st
    if (k == 0) begin : g_src0
      always_comb begin
        src[k]       = '0;
        src[k].ratio = dat_i.ratio;
        src[k].rot   = dat_i.cmd.rotor_angle;
      end
    end else begin : g_srcn
      always_comb begin
        src[k] = st_q[k-1];
      end
    end

    if (k == 0) begin : g_prep
      always_comb begin
        logic signed [33:0] xv, yv;
        xv      = $signed(dat_i.cmd.volt_d);
        yv      = $signed(dat_i.cmd.volt_q);
        xv      = xv <<< 14;
        yv      = yv <<< 14;
        st_d[k] = src[k];
        if (dat_i.cmd.volt_d == '0) begin
          st_d[k].xs = '0;
          st_d[k].ys = '0;
          if (dat_i.cmd.volt_q == '0) begin
            st_d[k].z = '0;
          end else if (dat_i.cmd.volt_q[15]) begin
            st_d[k].z = 32'hC000_0000;
          end else begin
            st_d[k].z = 32'h4000_0000;
          end
        end else if (xv[33]) begin
          st_d[k].xs = -xv;
          st_d[k].ys = -yv;
          st_d[k].z  = 32'h8000_0000;
        end else begin
          st_d[k].xs = xv;
          st_d[k].ys = yv;
          st_d[k].z  = '0;
        end
      end
    end else if (k <= CordicSteps) begin : g_cordic
      localparam int I = k - 1;
      always_comb begin
        logic signed [33:0] dx, dy;
        dx      = $signed(src[k].xs) >>> I;
        dy      = $signed(src[k].ys) >>> I;
        st_d[k] = src[k];
        if (src[k].ys != '0) begin
          if (!src[k].ys[33]) begin
            st_d[k].xs = src[k].xs + dy;
            st_d[k].ys = src[k].ys - dx;
            st_d[k].z  = src[k].z + atan_tab(I);
          end else begin
            st_d[k].xs = src[k].xs - dy;
            st_d[k].ys = src[k].ys + dx;
            st_d[k].z  = src[k].z - atan_tab(I);
          end
        end
      end
    end else if (k == CordicSteps + 1) begin : g_theta
      always_comb begin
        logic [32:0] sum;
        sum           = 33'(src[k].z) + (33'(1) << (31 - AngleBits));
        st_d[k]       = src[k];
        st_d[k].theta = AngleBits'(src[k].rot) + sum[31:32-AngleBits];
      end
    end else if (k == CordicSteps + 2) begin : g_sector
      always_comb begin
        logic [SixW-1:0] six;
        six        = SixW'(src[k].theta) * SixW'(6);
        st_d[k]    = src[k];
        st_d[k].sec = sector_e'(six[SixW-1:AngleBits]);
        st_d[k].fe  = 32'(six[AngleBits-1:0]) << (32 - AngleBits);
        st_d[k].fs  = 33'h1_0000_0000 - 33'(st_d[k].fe);
      end
    end else begin : g_div6
      always_comb begin
        logic [63:0] pe, ps;
        pe          = 64'(src[k].fe[31:1]) * 64'(Recip3);
        ps          = 64'(src[k].fs[32:1]) * 64'(Recip3);
        st_d[k]     = src[k];
        st_d[k].a_e = pe[63:33];
        st_d[k].a_s = ps[63:33];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NumSt; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vld_up[k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NumSt; k++) begin
      if (rdy[k] && vld_up[k]) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  assign rdy_o       = rdy[0];
  assign vld_o       = vld_q[NumSt-1];
  assign dat_o.ratio = st_q[NumSt-1].ratio;
  assign dat_o.sec   = st_q[NumSt-1].sec;
  assign dat_o.a_s   = st_q[NumSt-1].a_s;
  assign dat_o.a_e   = st_q[NumSt-1].a_e;
endmodule

/* rtl/core/ipsv_sin.sv */
module ipsv_sin (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           vld_i,
  output logic           rdy_o,
  input  ipsv_pkg::ang_t dat_i,
  output logic           vld_o,
  input  logic           rdy_i,
  output ipsv_pkg::snc_t dat_o
);
  import ipsv_pkg::*;

  localparam int unsigned NumSt = CordicSteps + 1;

  typedef struct packed {
    logic [17:0]      ratio;
    sector_e          sec;
    logic [1:0][32:0] x;
    logic [1:0][32:0] y;
    logic [1:0][32:0] z;
    logic [1:0][15:0] s;
  } st_t;

  st_t              st_q [NumSt];
  st_t              st_d [NumSt];
  st_t              src  [NumSt];
  logic [NumSt-1:0] vld_q, rdy, vld_up, rdy_dn;

  assign vld_up = {vld_q[NumSt-2:0], vld_i};
  assign rdy_dn = {rdy_i, rdy[NumSt-1:1]};
  assign rdy    = ~vld_q | rdy_dn;

  for (genvar k = 0; k < NumSt; k++) begin : g_st
    if (k == 0) begin : g_src0
      always_comb begin
        src[k]       = '0;
        src[k].ratio = dat_i.ratio;
        src[k].sec   = dat_i.sec;
        src[k].x[0]  = 33'(CordicGain);
        src[k].x[1]  = 33'(CordicGain);
        src[k].z[0]  = 33'(dat_i.a_s);
        src[k].z[1]  = 33'(dat_i.a_e);
      end
    end else begin : g_srcn
      always_comb begin
        src[k] = st_q[k-1];
      end
    end

    if (k < CordicSteps) begin : g_cordic
      always_comb begin
        logic signed [32:0] dx, dy;
        st_d[k] = src[k];
        for (int l = 0; l < 2; l++) begin
          dx = $signed(src[k].x[l]) >>> k;
          dy = $signed(src[k].y[l]) >>> k;
          if (!src[k].z[l][32]) begin
            st_d[k].x[l] = src[k].x[l] - dy;
            st_d[k].y[l] = src[k].y[l] + dx;
            st_d[k].z[l] = src[k].z[l] - 33'(atan_tab(k));
          end else begin
            st_d[k].x[l] = src[k].x[l] + dy;
            st_d[k].y[l] = src[k].y[l] - dx;
            st_d[k].z[l] = src[k].z[l] + 33'(atan_tab(k));
          end
        end
      end
    end else begin : g_round
      always_comb begin
        logic [32:0] r;
        st_d[k] = src[k];
        for (int l = 0; l < 2; l++) begin
          r = src[k].y[l] + 33'd16384;
          if (src[k].y[l][32]) begin
            st_d[k].s[l] = '0;
          end else if (r[32:15] > 18'd32768) begin
            st_d[k].s[l] = 16'd32768;
          end else begin
            st_d[k].s[l] = r[30:15];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NumSt; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vld_up[k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NumSt; k++) begin
      if (rdy[k] && vld_up[k]) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  assign rdy_o       = rdy[0];
  assign vld_o       = vld_q[NumSt-1];
  assign dat_o.ratio = st_q[NumSt-1].ratio;
  assign dat_o.sec   = st_q[NumSt-1].sec;
  assign dat_o.s     = st_q[NumSt-1].s;
endmodule

/* rtl/core/ipsv_duty.sv */
module ipsv_duty (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [15:0]    per_i,
  input  logic           vld_i,
  output logic           rdy_o,
  input  ipsv_pkg::snc_t dat_i,
  output logic           vld_o,
  input  logic           rdy_i,
  output ipsv_pkg::res_t dat_o
);
  import ipsv_pkg::*;

  localparam int unsigned NumSt = 6;

  typedef struct packed {
    sector_e          sec;
    logic [17:0]      ratio;
    logic [1:0][15:0] s;
    logic [32:0]      mk;
    logic [1:0][48:0] p;
    logic [1:0][17:0] t;
    logic [2:0][19:0] tf;
    logic [2:0][19:0] c;
    logic [2:0][15:0] duty;
  } st_t;

  st_t              st_q [NumSt];
  st_t              st_d [NumSt];
  st_t              src  [NumSt];
  logic [NumSt-1:0] vld_q, rdy, vld_up, rdy_dn;

  function automatic logic [19:0] clip_pos(input logic signed [20:0] v);
    return (v <= 0) ? '0 : v[19:0];
  endfunction

  assign vld_up = {vld_q[NumSt-2:0], vld_i};
  assign rdy_dn = {rdy_i, rdy[NumSt-1:1]};
  assign rdy    = ~vld_q | rdy_dn;

  for (genvar k = 0; k < NumSt; k++) begin : g_st
    if (k == 0) begin : g_src0
      always_comb begin
        src[k]       = '0;
        src[k].sec   = dat_i.sec;
        src[k].ratio = dat_i.ratio;
        src[k].s     = dat_i.s;
      end
    end else begin : g_srcn
      always_comb begin
        src[k] = st_q[k-1];
      end
    end

    if (k == 0) begin : g_gain
      always_comb begin
        st_d[k]    = src[k];
        st_d[k].mk = 33'(src[k].ratio) * 33'(Sqrt3Q15);
      end
    end else if (k == 1) begin : g_mul
      always_comb begin
        st_d[k] = src[k];
        for (int l = 0; l < 2; l++) begin
          st_d[k].p[l] = 49'(src[k].mk) * 49'(src[k].s[l]);
        end
      end
    end else if (k == 2) begin : g_rnd
      always_comb begin
        logic [48:0] r;
        st_d[k] = src[k];
        for (int l = 0; l < 2; l++) begin
          r            = src[k].p[l] + (49'(1) << 29);
          st_d[k].t[l] = r[47:30];
        end
      end
    end else if (k == 3) begin : g_sel
      always_comb begin
        logic signed [20:0] one, a, b, full, e1, e2, z0, du, dv, dw;
        one  = 21'sd32768;
        a    = 21'(src[k].t[0]);
        b    = 21'(src[k].t[1]);
        full = one + a + b;
        e1   = one + a - b;
        e2   = one - a + b;
        z0   = one - a - b;
        case (src[k].sec)
          SEC_1: begin
            du = full; dv = e2; dw = z0;
          end
          SEC_2: begin
            du = e1; dv = full; dw = z0;
          end
          SEC_3: begin
            du = z0; dv = full; dw = e2;
          end
          SEC_4: begin
            du = z0; dv = e1; dw = full;
          end
          SEC_5: begin
            du = e2; dv = z0; dw = full;
          end
          default: begin
            du = full; dv = z0; dw = e1;
          end
        endcase
        st_d[k]       = src[k];
        st_d[k].tf[0] = clip_pos(du);
        st_d[k].tf[1] = clip_pos(dv);
        st_d[k].tf[2] = clip_pos(dw);
      end
    end else if (k == 4) begin : g_scale
      always_comb begin
        logic [35:0] m;
        st_d[k] = src[k];
        for (int l = 0; l < 3; l++) begin
          m            = 36'(src[k].tf[l]) * 36'(per_i);
          st_d[k].c[l] = m[35:16];
        end
      end
    end else begin : g_clamp
      always_comb begin
        st_d[k] = src[k];
        for (int l = 0; l < 3; l++) begin
          st_d[k].duty[l] = (src[k].c[l] > 20'(per_i)) ? per_i : src[k].c[l][15:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NumSt; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vld_up[k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NumSt; k++) begin
      if (rdy[k] && vld_up[k]) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  assign rdy_o            = rdy[0];
  assign vld_o            = vld_q[NumSt-1];
  assign dat_o.duty_u     = st_q[NumSt-1].duty[0];
  assign dat_o.duty_v     = st_q[NumSt-1].duty[1];
  assign dat_o.duty_w     = st_q[NumSt-1].duty[2];
  assign dat_o.sector_num = 3'(st_q[NumSt-1].sec) + 3'd1;
endmodule
